// File: hw/rtl/utf_pkg.sv
// ----------------------------------------------------------------------------
// utf_pkg: shared types and constants of the UTF-8 / UTF-16 transcoder
// Item and result structs, the job record that runs from the front end to
// the back end, error codes, direction values and queue sizing.
// ----------------------------------------------------------------------------
package utf_pkg;

    // Error codes carried on every result
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_BAD_CONT = 2'd1;
    localparam logic [1:0] ERR_TRUNC    = 2'd2;

    // Direction register values
    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    // Job queue between front and back end
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef logic [QAW-1:0] t_qptr;
    typedef logic [QAW:0]   t_qcnt;

    // Input item
    typedef struct packed {
        logic [15:0] in_unit;
        logic        end_of_input;
    } t_in;

    // Result item
    typedef struct packed {
        logic [15:0] out_value;
        logic [1:0]  error_code;
        logic        last_of_run;
    } t_out;

    // All results caused by one input item (count is 1 to 3)
    typedef struct packed {
        logic [1:0]  count;
        logic [1:0]  err;
        logic [15:0] v0;
        logic [15:0] v1;
        logic [15:0] v2;
    } t_job;

endpackage

// File: hw/rtl/utf8_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_utf16_transcoder: UTF-8 to 16-bit unit decoder and unit encoder
// Each accepted item's job is written into the job queue, and its results are
// then loaded from the queue head into the output register one at a time.
// Throughput: one item per cycle while the 4-entry job queue has room; the
// queue absorbs bursts between the front and back end. Reset (synchronous,
// active low) selects decode and clears all but the queue and output data.
// ----------------------------------------------------------------------------
module utf8_utf16_transcoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  utf_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output utf_pkg::t_out o_out_data
);
    import utf_pkg::*;

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_valid;
    t_job push_job;
    t_job head_job;

    // Classify items into jobs
    utf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_job         (push_job)
    );

    // Buffer jobs
    utf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    // Emit results
    utf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: hw/rtl/utf_front.sv
// ----------------------------------------------------------------------------
// utf_front: input stage of the transcoder
// Accepts items, keeps the pending UTF-8 sequence, and turns each item into
// a job of one to three result values. Items that give no result push nothing.
// ----------------------------------------------------------------------------
module utf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_wr_en,
    input  logic          i_cfg_wr_data,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  utf_pkg::t_in  i_in_data,
    input  logic          i_q_full,
    output logic          o_push,
    output utf_pkg::t_job o_job
);
    import utf_pkg::*;

    logic        r_dir, n_dir;
    logic [1:0]  r_need, n_need;
    logic [1:0]  r_len, n_len;
    logic [20:0] r_acc, n_acc;

    logic        accept;
    logic [7:0]  byte_in;
    logic [15:0] unit;
    logic [20:0] acc_shift;
    logic [1:0]  need_dec;
    logic [9:0]  plane_m1;
    t_job        job;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign unit       = i_in_data.in_unit;
    assign byte_in    = unit[7:0];
    assign acc_shift  = {r_acc[14:0], byte_in[5:0]};
    assign need_dec   = r_need - 2'd1;
    // plane minus one, only the bits that survive the shift into 16 bits
    assign plane_m1   = {5'd0, acc_shift[20:16]} - 10'd1;

    // Classify the item and compute the next sequence state
    always_comb begin
        n_dir        = r_dir;
        n_need       = r_need;
        n_len        = r_len;
        n_acc        = r_acc;
        job          = '0;
        job.err      = ERR_OK;

        if (accept) begin
            if (r_dir == DIR_ENCODE) begin
                if (unit < 16'h0080) begin
                    job.count = 2'd1;
                    job.v0    = unit;
                end else if (unit < 16'h0800) begin
                    job.count = 2'd2;
                    job.v0    = 16'h00C0 | {6'd0, unit[15:6]};
                    job.v1    = 16'h0080 | {10'd0, unit[5:0]};
                end else begin
                    job.count = 2'd3;
                    job.v0    = 16'h00E0 | {12'd0, unit[15:12]};
                    job.v1    = 16'h0080 | {10'd0, unit[11:6]};
                    job.v2    = 16'h0080 | {10'd0, unit[5:0]};
                end
            end else if (r_need == 2'd0) begin
                if (byte_in <= 8'h7F) begin
                    job.count = 2'd1;
                    job.v0    = {8'd0, byte_in};
                end else begin
                    if (byte_in <= 8'hDF) begin
                        n_len = 2'd1;
                        n_acc = {16'd0, byte_in[4:0]};
                    end else if (byte_in <= 8'hEF) begin
                        n_len = 2'd2;
                        n_acc = {17'd0, byte_in[3:0]};
                    end else begin
                        n_len = 2'd3;
                        n_acc = {18'd0, byte_in[2:0]};
                    end
                    n_need = n_len;
                    // cut off right after the lead byte
                    if (i_in_data.end_of_input) begin
                        n_need    = 2'd0;
                        n_len     = 2'd0;
                        n_acc     = '0;
                        job.count = 2'd1;
                        job.err   = ERR_TRUNC;
                    end
                end
            end else if (byte_in < 8'h80) begin
                // bad continuation: drop the byte and the sequence
                n_need    = 2'd0;
                n_len     = 2'd0;
                n_acc     = '0;
                job.count = 2'd1;
                job.err   = ERR_BAD_CONT;
            end else begin
                n_acc  = acc_shift;
                n_need = need_dec;
                if (need_dec == 2'd0) begin
                    if (r_len == 2'd3) begin
                        job.count = 2'd2;
                        job.v0    = 16'hD800 | {plane_m1, 6'd0}
                                    | {10'd0, acc_shift[15:10]};
                        job.v1    = 16'hDC00 | {6'd0, acc_shift[9:0]};
                    end else begin
                        job.count = 2'd1;
                        job.v0    = acc_shift[15:0];
                    end
                    n_len = 2'd0;
                    n_acc = '0;
                end else if (i_in_data.end_of_input) begin
                    n_need    = 2'd0;
                    n_len     = 2'd0;
                    n_acc     = '0;
                    job.count = 2'd1;
                    job.err   = ERR_TRUNC;
                end
            end
        end

        // Direction write drops any pending sequence
        if (i_cfg_wr_en) begin
            n_dir  = i_cfg_wr_data;
            n_need = 2'd0;
            n_len  = 2'd0;
            n_acc  = '0;
        end
    end

    assign o_push = accept && (job.count != 2'd0);
    assign o_job  = job;

    // Hold direction and sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir  <= DIR_DECODE;
            r_need <= 2'd0;
            r_len  <= 2'd0;
            r_acc  <= '0;
        end else begin
            r_dir  <= n_dir;
            r_need <= n_need;
            r_len  <= n_len;
            r_acc  <= n_acc;
        end
    end

    a_need_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_need <= r_len)
        else $error("pending byte count exceeds sequence length");

endmodule

// File: hw/rtl/utf_queue.sv
// ----------------------------------------------------------------------------
// utf_queue: job queue between front and back end
// Small register FIFO; the back end reads the head job in place.
// ----------------------------------------------------------------------------
module utf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  utf_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output utf_pkg::t_job o_head
);
    import utf_pkg::*;

    t_job  r_mem [QDEPTH];
    t_qptr r_wr_ptr, n_wr_ptr;
    t_qptr r_rd_ptr, n_rd_ptr;
    t_qcnt r_count, n_count;

    assign o_full  = (r_count == t_qcnt'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + t_qptr'(1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + t_qptr'(1) : r_rd_ptr;
        n_count  = r_count + t_qcnt'(i_push) - t_qcnt'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full job queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty job queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_qcnt'(QDEPTH))
        else $error("job queue count out of range");

endmodule

// File: hw/rtl/utf_back.sv
// ----------------------------------------------------------------------------
// utf_back: output stage of the transcoder
// Walks the head job one value per cycle into the output register, while that
// register is empty or being taken, and marks the last result of each job.
// ----------------------------------------------------------------------------
module utf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  utf_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output utf_pkg::t_out o_out_data
);
    import utf_pkg::*;

    logic [1:0]  r_idx, n_idx;
    logic        r_valid, n_valid;
    t_out        r_out, n_out;
    logic        load;
    logic        is_last;
    logic [15:0] sel_value;

    assign load    = i_q_valid && (!r_valid || i_out_ready);
    assign is_last = (r_idx == (i_head.count - 2'd1));

    // Pick the value at the current index
    always_comb begin
        case (r_idx)
            2'd0:    sel_value = i_head.v0;
            2'd1:    sel_value = i_head.v1;
            default: sel_value = i_head.v2;
        endcase
    end

    // Load the next result or drain the output register
    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_out   = r_out;
        if (load) begin
            n_valid           = 1'b1;
            n_out.out_value   = sel_value;
            n_out.error_code  = i_head.err;
            n_out.last_of_run = is_last;
            n_idx             = is_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    assign o_pop       = load && is_last;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_err_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_out.error_code != ERR_OK) |->
            (r_out.out_value == 16'd0) && r_out.last_of_run)
        else $error("error result with value or without end of run");

    a_idx_in_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx < i_head.count))
        else $error("result index past end of job");

endmodule

// File: sim/utf8_utf16_transcoder_tb.sv
// ----------------------------------------------------------------------------
// utf8_utf16_transcoder_tb: self-checking bench for the UTF-8 transcoder
// Drives bytes or 16-bit units through the valid/ready input, runs them
// through a bit-true decoder/encoder kept in the bench, and compares every
// output transfer field by field against the oldest predicted result.
// Directed cases cover the sequence classes and error paths, then random
// loosely formed UTF-8 with broken sequences and noise, random units in
// encode mode, and long output stalls that back the block up.
// ----------------------------------------------------------------------------
module utf8_utf16_transcoder_tb;

    import utf_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PCT      = 20;

    logic i_clk         = 1'b0;
    logic i_rst_n       = 1'b0;
    logic i_cfg_wr_en   = 1'b0;
    logic i_cfg_wr_data = 1'b0;
    logic i_in_valid    = 1'b0;
    t_in  i_in_data     = '0;
    logic i_out_ready   = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_data;

    // Transcoder state mirrored in the bench
    logic        dir_q  = DIR_DECODE;
    logic [1:0]  need_q = '0;
    logic [1:0]  len_q  = '0;
    logic [20:0] acc_q  = '0;

    t_out pending_outputs[$];
    t_out oldest_out;
    int   mismatch_count = 0;
    bit   idle_en        = 1'b1;
    int   hold_request   = 0;
    int   hold_left      = 0;

    utf8_utf16_transcoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void push_unit(input logic [15:0] value, input logic [1:0] err,
                                      input logic last);
        t_out r;
        r.out_value   = value;
        r.error_code  = err;
        r.last_of_run = last;
        pending_outputs.push_back(r);
    endfunction

    function automatic void clear_sequence();
        need_q = '0;
        len_q  = '0;
        acc_q  = '0;
    endfunction

    // Compute the results of one accepted item and advance the mirrored state
    task automatic transcode_item(input t_in item);
        logic [15:0] u;
        logic [7:0]  b;
        logic [15:0] plane;
        logic [15:0] hi;
        logic [15:0] lo;
        u = item.in_unit;
        b = u[7:0];
        // Encode: one unit to 1..3 bytes
        if (dir_q == DIR_ENCODE) begin
            if (u < 16'h0080) begin
                push_unit(u, ERR_OK, 1'b1);
            end else if (u < 16'h0800) begin
                push_unit(16'h00C0 | (u >> 6), ERR_OK, 1'b0);
                push_unit(16'h0080 | (u & 16'h003F), ERR_OK, 1'b1);
            end else begin
                push_unit(16'h00E0 | (u >> 12), ERR_OK, 1'b0);
                push_unit(16'h0080 | ((u >> 6) & 16'h003F), ERR_OK, 1'b0);
                push_unit(16'h0080 | (u & 16'h003F), ERR_OK, 1'b1);
            end
            return;
        end
        // Decode: lead byte opens a sequence
        if (need_q == 2'd0) begin
            if (b <= 8'h7F) begin
                push_unit({8'h00, b}, ERR_OK, 1'b1);
                return;
            end
            if (b <= 8'hDF) begin
                len_q = 2'd1;
                acc_q = {16'h0, b[4:0]};
            end else if (b <= 8'hEF) begin
                len_q = 2'd2;
                acc_q = {17'h0, b[3:0]};
            end else begin
                len_q = 2'd3;
                acc_q = {18'h0, b[2:0]};
            end
            need_q = len_q;
        end else begin
            // Continuation: only the top bit is checked
            if (b < 8'h80) begin
                clear_sequence();
                push_unit(16'h0000, ERR_BAD_CONT, 1'b1);
                return;
            end
            acc_q  = {acc_q[14:0], b[5:0]};
            need_q = need_q - 2'd1;
            if (need_q == 2'd0) begin
                if (len_q == 2'd3) begin
                    plane = {11'h0, acc_q[20:16]} - 16'd1;
                    hi    = 16'hD800 | (plane << 6) | {10'h0, acc_q[15:10]};
                    lo    = 16'hDC00 | {6'h0, acc_q[9:0]};
                    push_unit(hi, ERR_OK, 1'b0);
                    push_unit(lo, ERR_OK, 1'b1);
                end else begin
                    push_unit(acc_q[15:0], ERR_OK, 1'b1);
                end
                clear_sequence();
                return;
            end
        end
        // End of buffer inside a sequence
        if (item.end_of_input) begin
            clear_sequence();
            push_unit(16'h0000, ERR_TRUNC, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random ready, plus a counted hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("unexpected result: out_value %h error_code %0d last_of_run %0b",
                       o_out_data.out_value, o_out_data.error_code, o_out_data.last_of_run);
                mismatch_count++;
            end else begin
                oldest_out = pending_outputs.pop_front();
                if (o_out_data.out_value !== oldest_out.out_value) begin
                    $error("out_value: expected %h, actual %h",
                           oldest_out.out_value, o_out_data.out_value);
                    mismatch_count++;
                end
                if (o_out_data.error_code !== oldest_out.error_code) begin
                    $error("error_code: expected %0d, actual %0d",
                           oldest_out.error_code, o_out_data.error_code);
                    mismatch_count++;
                end
                if (o_out_data.last_of_run !== oldest_out.last_of_run) begin
                    $error("last_of_run: expected %0b, actual %0b",
                           oldest_out.last_of_run, o_out_data.last_of_run);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared stimulus tasks
    // ------------------------------------------------------------------
    // Offer one item, hold it until the transfer, then maybe idle
    task automatic send_item(input logic [15:0] unit, input logic eoi);
        t_in item;
        item.in_unit      = unit;
        item.end_of_input = eoi;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        transcode_item(item);
        if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < IDLE_PCT);
        end
    endtask

    // Drop valid, wait for every predicted result, then let the pipe go quiet
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic dir);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= dir;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        dir_q = dir;
        clear_sequence();
        @(posedge i_clk);
    endtask

    // One UTF-8 character with random payload; flaw 1 breaks a
    // continuation, flaw 2 ends the buffer inside the sequence
    task automatic send_utf8_char(input int flaw);
        int          len;
        int          cut;
        int          k;
        logic [7:0]  b;
        logic [7:0]  lead;
        logic [7:0]  hi8;
        logic [5:0]  payload;
        logic        eoi;
        len = (flaw == 0) ? $urandom_range(1, 4) : $urandom_range(2, 4);
        cut = (len > 1) ? $urandom_range(1, len - 1) : 1;
        case (len)
            1: lead = 8'($urandom_range(8'h00, 8'h7F));
            2: lead = 8'($urandom_range(8'h80, 8'hDF));
            3: lead = 8'($urandom_range(8'hE0, 8'hEF));
            default: lead = 8'($urandom_range(8'hF0, 8'hFF));
        endcase
        for (k = 0; k < len; k++) begin
            payload = 6'($urandom_range(0, 63));
            hi8     = 8'($urandom_range(0, 255));
            if (k == 0)
                b = lead;
            else if ($urandom_range(0, 9) == 0)
                b = 8'($urandom_range(8'hC0, 8'hFF));
            else
                b = {2'b10, payload};
            if (flaw == 1 && k == cut)
                b = 8'($urandom_range(8'h00, 8'h7F));
            if (flaw == 2)
                eoi = (k == cut - 1);
            else
                eoi = (k == len - 1) && ($urandom_range(0, 9) == 0);
            send_item({hi8, b}, eoi);
            if ((flaw == 1 && k == cut) || (flaw == 2 && k == cut - 1))
                break;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_decode_directed();
        send_item(16'h0000, 1'b0);
        send_item(16'hFF7F, 1'b1);          // upper bits ignored, eoi on a lone byte
        send_item(16'h00C3, 1'b0);
        send_item(16'h12A9, 1'b0);
        send_item(16'h00E2, 1'b0);
        send_item(16'h0082, 1'b0);
        send_item(16'h00AC, 1'b0);
        send_item(16'h00F0, 1'b0);          // four bytes to a surrogate pair
        send_item(16'h009F, 1'b0);
        send_item(16'h0098, 1'b0);
        send_item(16'h0080, 1'b0);
        send_item(16'h00F0, 1'b0);          // plane zero in four bytes wraps
        send_item(16'h008F, 1'b0);
        send_item(16'h00BF, 1'b0);
        send_item(16'h00BF, 1'b0);
        send_item(16'h0080, 1'b0);          // stray continuation taken as a lead
        send_item(16'h0080, 1'b0);
        send_item(16'h00C3, 1'b0);          // byte at or above 0xC0 continues
        send_item(16'h00C3, 1'b0);
        send_item(16'h00E2, 1'b0);          // bad continuation
        send_item(16'h0041, 1'b0);
        send_item(16'h00C3, 1'b0);          // bad continuation with eoi
        send_item(16'h0041, 1'b1);
        send_item(16'h00E2, 1'b0);          // truncated sequence
        send_item(16'h0082, 1'b1);
        send_item(16'hFFFF, 1'b1);          // lead byte with eoi
        drain_outputs();
    endtask

    task automatic test_direction_write();
        // Any write drops a pending sequence
        send_item(16'h00E2, 1'b0);
        drain_outputs();
        write_direction(DIR_DECODE);
        send_item(16'h0041, 1'b0);
        send_item(16'h00C3, 1'b0);
        drain_outputs();
        write_direction(DIR_ENCODE);
        write_direction(DIR_DECODE);
        send_item(16'h0082, 1'b1);
        drain_outputs();
    endtask

    task automatic test_encode_directed();
        write_direction(DIR_ENCODE);
        send_item(16'h0000, 1'b0);
        send_item(16'h007F, 1'b0);
        send_item(16'h0080, 1'b0);
        send_item(16'h07FF, 1'b0);
        send_item(16'h0800, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'hD83D, 1'b0);
        send_item(16'h5555, 1'b1);          // eoi has no effect here
        send_item(16'hAAAA, 1'b1);
        drain_outputs();
    endtask

    task automatic test_decode_random();
        int n;
        int pick;
        write_direction(DIR_DECODE);
        // Back-to-back stretch with no idling on either side
        idle_en = 1'b0;
        for (n = 0; n < 110; n++) begin
            if (n == 40)
                idle_en = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_utf8_char(0);
            else if (pick < 80)
                send_utf8_char(1);
            else if (pick < 88)
                send_utf8_char(2);
            else
                send_item(16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)));
        end
        drain_outputs();
    endtask

    task automatic test_encode_random();
        int          n;
        int          pick;
        logic [15:0] unit;
        write_direction(DIR_ENCODE);
        for (n = 0; n < 140; n++) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: unit = 16'($urandom_range(16'h0000, 16'h007F));
                1: unit = 16'($urandom_range(16'h0080, 16'h07FF));
                2: unit = 16'($urandom_range(16'h0800, 16'hFFFF));
                default: unit = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_item(unit, 1'($urandom_range(0, 1)));
        end
        drain_outputs();
    endtask

    task automatic test_backpressure();
        int n;
        // Stall the output long enough for the job queue to fill
        hold_request = 80;
        for (n = 0; n < 20; n++)
            send_item(16'($urandom_range(16'h0800, 16'hFFFF)), 1'b0);
        // Pause the sender until every result has left
        i_in_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        for (n = 0; n < 10; n++)
            send_item(16'($urandom_range(0, 16'hFFFF)), 1'b0);
        drain_outputs();
        write_direction(DIR_DECODE);
        hold_request = 60;
        for (n = 0; n < 12; n++)
            send_utf8_char(0);
        drain_outputs();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_decode_directed();
        test_direction_write();
        test_encode_directed();
        test_decode_random();
        test_encode_random();
        test_backpressure();
        if (mismatch_count == 0 && pending_outputs.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
